### rtl/modinv_pkg.sv
// ----------------------------------------------------------------------------
// modinv_pkg
// Shared types, constants and the control store of the modular inverse core.
// ----------------------------------------------------------------------------
package modinv_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);
    localparam int PC_WIDTH   = 3;

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [CNT_WIDTH-1:0]  cnt_t;
    typedef logic [PC_WIDTH-1:0]   pc_t;

    typedef struct packed {
        word_t value;
        word_t modulus;
    } in_item_t;

    typedef struct packed {
        word_t inverse;
        word_t divisor;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_NOP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_EUCLID_UPD,
        OP_RED_INIT,
        OP_RESULT
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_START,
        COND_R1_ZERO,
        COND_DIV_MORE,
        COND_OUT_BLOCKED
    } cond_t;

    typedef struct packed {
        op_t   op;
        logic  take_in;
        cond_t cond;
        pc_t   target;
    } ctl_t;

    localparam cnt_t DIV_LAST = cnt_t'(DATA_WIDTH - 1);

    localparam pc_t PC_WAIT     = pc_t'(0);
    localparam pc_t PC_CHECK    = pc_t'(1);
    localparam pc_t PC_DIV_INIT = pc_t'(2);
    localparam pc_t PC_DIV_LOOP = pc_t'(3);
    localparam pc_t PC_UPDATE   = pc_t'(4);
    localparam pc_t PC_RED_INIT = pc_t'(5);
    localparam pc_t PC_RED_LOOP = pc_t'(6);
    localparam pc_t PC_RESULT   = pc_t'(7);

    // control store: jump to target when cond holds, else step on
    // (the last step wraps to the wait step)
    function automatic ctl_t ucode(pc_t pc);
        ctl_t w;
        w = '{op: OP_NOP, take_in: 1'b0, cond: COND_ALWAYS, target: PC_WAIT};
        case (pc)
            PC_WAIT:     w = '{op: OP_IDLE,       take_in: 1'b1,
                               cond: COND_NO_START,    target: PC_WAIT};
            PC_CHECK:    w = '{op: OP_NOP,        take_in: 1'b0,
                               cond: COND_R1_ZERO,     target: PC_RED_INIT};
            PC_DIV_INIT: w = '{op: OP_DIV_INIT,   take_in: 1'b0,
                               cond: COND_NEVER,       target: PC_WAIT};
            PC_DIV_LOOP: w = '{op: OP_DIV_STEP,   take_in: 1'b0,
                               cond: COND_DIV_MORE,    target: PC_DIV_LOOP};
            PC_UPDATE:   w = '{op: OP_EUCLID_UPD, take_in: 1'b0,
                               cond: COND_ALWAYS,      target: PC_CHECK};
            PC_RED_INIT: w = '{op: OP_RED_INIT,   take_in: 1'b0,
                               cond: COND_NEVER,       target: PC_WAIT};
            PC_RED_LOOP: w = '{op: OP_DIV_STEP,   take_in: 1'b0,
                               cond: COND_DIV_MORE,    target: PC_RED_LOOP};
            PC_RESULT:   w = '{op: OP_RESULT,     take_in: 1'b0,
                               cond: COND_OUT_BLOCKED, target: PC_RESULT};
            default:     w = '{op: OP_NOP,        take_in: 1'b0,
                               cond: COND_ALWAYS,      target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

### rtl/modular_inverse_ext_euclid_core.sv
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_core
// Modular inverse and gcd by the extended Euclidean algorithm.
//
// Input channel in_valid/in_stall/in_data carries value and modulus; output
// channel out_valid/out_stall/out_data returns the Bezout coefficient of the
// value reduced modulo the modulus (inverse) and the gcd (divisor). The
// inverse is a true inverse when divisor is one.
// One transaction is worked at a time; in_stall is high from acceptance
// until the sequencer is back at its wait step.
// The number of Euclid steps for a pair is at most about 1.44 * DATA_WIDTH,
// about 47 at 32 bits. Each step runs one division, and the final reduction
// one more; all of them run through one restoring divider that retires one
// quotient bit per cycle.
// The result sits in an output register; the next transaction is accepted
// while it waits. A stalled result holds, and the sequencer waits at its
// last step only when a new result is ready before the old one is taken.
// Reset returns the sequencer to its wait step and empties the output.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  modinv_pkg::in_item_t  in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output modinv_pkg::out_item_t out_data
);

    localparam int W = modinv_pkg::DATA_WIDTH;

    modinv_pkg::pc_t       pc_reg, pc_next;
    modinv_pkg::ctl_t      ctl;
    modinv_pkg::word_t     r0_reg, r0_next;
    modinv_pkg::word_t     r1_reg, r1_next;
    modinv_pkg::word_t     c0_reg, c0_next;
    modinv_pkg::word_t     c1_reg, c1_next;
    logic                  n0_reg, n0_next;
    logic                  n1_reg, n1_next;
    modinv_pkg::word_t     m_reg, m_next;
    modinv_pkg::word_t     rem_reg, rem_next;
    modinv_pkg::word_t     dvd_reg, dvd_next;
    modinv_pkg::word_t     dsr_reg, dsr_next;
    modinv_pkg::word_t     t_reg, t_next;
    modinv_pkg::cnt_t      cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    modinv_pkg::out_item_t out_data_reg, out_data_next;

    logic                  in_take;
    logic                  out_free;
    logic                  cond_hit;
    logic [W:0]            shifted;
    logic                  qbit;
    modinv_pkg::word_t     red;
    modinv_pkg::word_t     inv_val;

    assign ctl      = modinv_pkg::ucode(pc_reg);
    assign in_stall = !ctl.take_in;
    assign in_take  = in_valid && ctl.take_in;
    assign out_free = !out_valid_reg || !out_stall;

    // one restoring division step
    assign shifted = {rem_reg, dvd_reg[W-1]};
    assign qbit    = (shifted >= {1'b0, dsr_reg});

    // final reduction of the coefficient
    assign red     = rem_reg;
    assign inv_val = (m_reg == '0) ? '0
                   : ((n0_reg && (red != '0)) ? (m_reg - red) : red);

    always_comb
    begin
        case (ctl.cond)
            modinv_pkg::COND_NEVER:       cond_hit = 1'b0;
            modinv_pkg::COND_ALWAYS:      cond_hit = 1'b1;
            modinv_pkg::COND_NO_START:    cond_hit = !in_take;
            modinv_pkg::COND_R1_ZERO:     cond_hit = (r1_reg == '0);
            modinv_pkg::COND_DIV_MORE:    cond_hit = (cnt_reg != modinv_pkg::DIV_LAST);
            modinv_pkg::COND_OUT_BLOCKED: cond_hit = !out_free;
            default:                      cond_hit = 1'b0;
        endcase
    end

    assign pc_next = cond_hit ? ctl.target : pc_reg + 1'b1;

    always_comb
    begin
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        c0_next        = c0_reg;
        c1_next        = c1_reg;
        n0_next        = n0_reg;
        n1_next        = n1_reg;
        m_next         = m_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        dsr_next       = dsr_reg;
        t_next         = t_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        case (ctl.op)
            modinv_pkg::OP_IDLE:
            begin
                if (in_take)
                begin
                    r0_next = in_data.modulus;
                    r1_next = in_data.value;
                    c0_next = '0;
                    c1_next = modinv_pkg::word_t'(1);
                    n0_next = 1'b0;
                    n1_next = 1'b0;
                    m_next  = in_data.modulus;
                end
            end
            modinv_pkg::OP_DIV_INIT:
            begin
                rem_next = '0;
                dvd_next = r0_reg;
                dsr_next = r1_reg;
                t_next   = '0;
                cnt_next = '0;
            end
            modinv_pkg::OP_DIV_STEP:
            begin
                rem_next = qbit ? W'(shifted - {1'b0, dsr_reg}) : shifted[W-1:0];
                dvd_next = {dvd_reg[W-2:0], 1'b0};
                // quotient times current coefficient, built msb first
                t_next   = {t_reg[W-2:0], 1'b0} + (qbit ? c1_reg : '0);
                cnt_next = cnt_reg + 1'b1;
            end
            modinv_pkg::OP_EUCLID_UPD:
            begin
                r0_next = r1_reg;
                r1_next = rem_reg;
                c0_next = c1_reg;
                c1_next = c0_reg + t_reg;
                n0_next = n1_reg;
                n1_next = !n1_reg;
            end
            modinv_pkg::OP_RED_INIT:
            begin
                rem_next = '0;
                dvd_next = c0_reg;
                dsr_next = m_reg;
                t_next   = '0;
                cnt_next = '0;
            end
            modinv_pkg::OP_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_data_next.inverse = inv_val;
                    out_data_next.divisor = r0_reg;
                end
            end
            modinv_pkg::OP_NOP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= modinv_pkg::PC_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_reg       <= r0_next;
        r1_reg       <= r1_next;
        c0_reg       <= c0_next;
        c1_reg       <= c1_next;
        n0_reg       <= n0_next;
        n1_reg       <= n1_next;
        m_reg        <= m_next;
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        dsr_reg      <= dsr_next;
        t_reg        <= t_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### rtl/modinv_checker.sv
// ----------------------------------------------------------------------------
// modinv_checker
// Port-level checks for the modular inverse core, bound to its top level.
// ----------------------------------------------------------------------------
module modinv_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input modinv_pkg::in_item_t  in_data,
    input logic                  out_valid,
    input logic                  out_stall,
    input modinv_pkg::out_item_t out_data
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transaction dropped while stalled");

    // stalled result does not change
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("output payload changed while stalled");

    // one transaction in flight: stall right after acceptance
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while busy");

    // a new result is produced only while the input side is held off
    a_result_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a transaction in flight");

endmodule

bind modular_inverse_ext_euclid_core modinv_checker u_modinv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
